[hdl/idta_pkg.sv]
// ----------------------------------------------------------------------------
// Integer to decimal ASCII package
// Shared widths, character codes and the command bundle that drives the
// decimal digit shift register.
// ----------------------------------------------------------------------------
package idta_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int DIGIT_SLOTS_DEF = 20;

  localparam int IN_VALUE_W = 64;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef logic [DIGIT_W-1:0] digit_t;

  // Commands to the decimal register; at most one is raised in a cycle.
  typedef struct packed {
    logic clear;  // zero all digits and the overflow flag
    logic step;   // double the register and add the incoming bit
    logic shift;  // move every digit one place up, dropping the top digit
  } bcd_cmd_t;

endpackage

[hdl/idta_if.sv]
// ----------------------------------------------------------------------------
// Integer to decimal ASCII channel interfaces
// Valid/ready channels for the input words and the output characters.
// ----------------------------------------------------------------------------
interface idta_in_if
  import idta_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [IN_VALUE_W-1:0] value;
  logic                  is_signed;

  modport source (output valid, output value, output is_signed, input ready);
  modport sink   (input valid, input value, input is_signed, output ready);
endinterface

interface idta_out_if
  import idta_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

[hdl/idta_bin_shift.sv]
// ----------------------------------------------------------------------------
// Binary magnitude shift register
// Forms the unsigned magnitude of the word and hands it out one bit per
// cycle while shift is raised, most significant bit first.
// ----------------------------------------------------------------------------
module idta_bin_shift
  import idta_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   load,
  input  logic                   negate,
  input  logic [VALUE_WIDTH-1:0] word,
  input  logic                   shift,
  output logic                   bit_out
);

  logic [VALUE_WIDTH-1:0] mag_r;
  logic [VALUE_WIDTH-1:0] mag_nxt;

  always_comb begin
    mag_nxt = mag_r;
    if (load) begin
      // Two's complement negation within the word width; the most negative
      // value maps onto its own bit pattern, which is the correct magnitude.
      mag_nxt = negate ? (~word + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : word;
    end else if (shift) begin
      mag_nxt = {mag_r[VALUE_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
  end

  assign bit_out = mag_r[VALUE_WIDTH-1];

endmodule

[hdl/idta_bcd_shift.sv]
// ----------------------------------------------------------------------------
// Decimal digit shift register
// Builds the decimal form by shift-and-add-three, one bit per cycle on step,
// then hands digits out one per cycle on shift from the most significant slot.
// ----------------------------------------------------------------------------
module idta_bcd_shift
  import idta_pkg::*;
#(
  parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  bcd_cmd_t cmd,
  input  logic     bit_in,
  output digit_t   top_digit,
  output logic     overflow
);

  digit_t bcd_r   [DIGIT_SLOTS];
  digit_t bcd_nxt [DIGIT_SLOTS];
  digit_t adj     [DIGIT_SLOTS];
  logic   ovf_r;
  logic   ovf_nxt;

  // Each digit of five or more gets three added so that doubling it carries
  // correctly into the next decimal place.
  always_comb begin
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? (bcd_r[i] + 4'd3) : bcd_r[i];
    end
  end

  always_comb begin
    bcd_nxt = bcd_r;
    ovf_nxt = ovf_r;
    if (cmd.clear) begin
      for (int i = 0; i < DIGIT_SLOTS; i++) begin
        bcd_nxt[i] = '0;
      end
      ovf_nxt = 1'b0;
    end else if (cmd.step) begin
      bcd_nxt[0] = {adj[0][2:0], bit_in};
      for (int i = 1; i < DIGIT_SLOTS; i++) begin
        bcd_nxt[i] = {adj[i][2:0], adj[i-1][3]};
      end
      // A carry out of the top slot means the value needs more slots than
      // exist; the value only grows, so the flag stays set.
      ovf_nxt = ovf_r | adj[DIGIT_SLOTS-1][3];
    end else if (cmd.shift) begin
      bcd_nxt[0] = '0;
      for (int i = 1; i < DIGIT_SLOTS; i++) begin
        bcd_nxt[i] = bcd_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r <= 1'b0;
    end else begin
      ovf_r <= ovf_nxt;
    end
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[DIGIT_SLOTS-1];
  assign overflow  = ovf_r;

endmodule

[hdl/integer_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// Integer to decimal ASCII converter
// Turns a binary word, signed or unsigned, into its decimal text, one
// character per output transaction, most significant digit first.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload                       Transaction
//  in_ch    sink       value[63:0], is_signed        one word to convert
//  out_ch   source     character[7:0], last          one ASCII character
//
// The conversion is bit-serial: the magnitude is shifted into the decimal
// register one bit per cycle. Leading zero slots are then dropped one per
// cycle, and each character leaves through the output register one per
// cycle while the sink is ready.
// Reset is synchronous and active low; it returns the sequencer to idle and
// empties the output register.
// A stalled sink holds the sequencer at the character it is about to send.
// The next word is accepted once the final character sits in the output
// register, even while that character still waits to be taken.
//
module integer_to_decimal_ascii
  import idta_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  idta_in_if.sink    in_ch,
  idta_out_if.source out_ch
);

  localparam int BIT_CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int DIG_CNT_W = $clog2(DIGIT_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_SIGN,
    S_DIGIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0]   dig_cnt_r, dig_cnt_nxt;
  logic                   neg_r, neg_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   in_accept;
  logic                   out_free;
  logic                   word_neg;
  logic                   mag_bit;
  bcd_cmd_t               bcd_cmd;
  digit_t                 top_digit;
  logic                   overflow;

  // The sequencer only takes a word while idle; the output register is
  // independent, so the last character of the previous word may still wait.
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign word_neg    = in_ch.is_signed && in_ch.value[VALUE_WIDTH-1];

  idta_bin_shift #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_bin (
    .clk     (clk),
    .load    (in_accept),
    .negate  (word_neg),
    .word    (in_ch.value[VALUE_WIDTH-1:0]),
    .shift   (state_r == S_CONV),
    .bit_out (mag_bit)
  );

  idta_bcd_shift #(
    .DIGIT_SLOTS (DIGIT_SLOTS)
  ) u_bcd (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (bcd_cmd),
    .bit_in    (mag_bit),
    .top_digit (top_digit),
    .overflow  (overflow)
  );

  always_comb begin
    state_nxt     = state_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    bcd_cmd       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          bcd_cmd.clear = 1'b1;
          neg_nxt       = word_neg;
          bit_cnt_nxt   = BIT_CNT_W'(VALUE_WIDTH - 1);
          state_nxt     = S_CONV;
        end
      end
      S_CONV: begin
        bcd_cmd.step = 1'b1;
        if (bit_cnt_r == '0) begin
          dig_cnt_nxt = DIG_CNT_W'(DIGIT_SLOTS);
          state_nxt   = S_SKIP;
        end else begin
          bit_cnt_nxt = bit_cnt_r - 1'b1;
        end
      end
      S_SKIP: begin
        // Drop leading zeros but always keep the units digit. When the value
        // overflowed the slots every slot is printed, zeros included.
        if (!overflow && top_digit == '0 && dig_cnt_r != DIG_CNT_W'(1)) begin
          bcd_cmd.shift = 1'b1;
          dig_cnt_nxt   = dig_cnt_r - 1'b1;
        end else begin
          state_nxt = neg_r ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
          out_last_nxt  = (dig_cnt_r == DIG_CNT_W'(1));
          bcd_cmd.shift = 1'b1;
          dig_cnt_nxt   = dig_cnt_r - 1'b1;
          if (dig_cnt_r == DIG_CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bit_cnt_r  <= bit_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;

  // Every character sent is a minus sign or a decimal digit.
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r == CHAR_MINUS) ||
                    (out_char_r >= CHAR_ZERO && out_char_r <= CHAR_NINE))
    else $error("character outside the decimal alphabet");

  // The text never ends on the sign.
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_char_r == CHAR_MINUS) |-> !out_last_r)
    else $error("minus sign marked as final character");

  // While digits are pending the remaining count never runs out.
  a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SKIP || state_r == S_SIGN || state_r == S_DIGIT) |->
      dig_cnt_r != '0)
    else $error("digit count exhausted before the final character");

  // A word is taken only once the previous text has fully left the sequencer.
  a_accept_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIGIT && state_nxt == S_IDLE) |=> (out_valid_r && out_last_r))
    else $error("final character not loaded when the sequencer went idle");

endmodule

[verif/tb_integer_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// Integer to decimal ASCII converter testbench
// Sends 64-bit words, signed and unsigned, and checks every character and its
// last flag against a behavioral decimal conversion. Idling on both channels
// changes from phase to phase, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_integer_to_decimal_ascii
  import idta_pkg::*;
();

  // The block is built at its default sizes, and the prediction uses the same.
  localparam int VW = VALUE_WIDTH_DEF;
  localparam int DS = DIGIT_SLOTS_DEF;

  localparam logic [IN_VALUE_W-1:0] WORD_MASK = {IN_VALUE_W{1'b1}} >> (IN_VALUE_W - VW);

  // Words per idling phase, and the longest run of cycles with no transaction
  // on either channel before the run is declared hung. The limit covers the
  // long receiver hold-off plus a full conversion and random stalls.
  localparam int PHASE_WORDS    = 80;
  localparam int HOLD_OFF_LEN   = 600;
  localparam int DRAIN_CYCLES   = 2 * (VW + DS + 3);
  localparam int WATCHDOG_LIMIT = 5000;

  // Idling modes, one per random phase.
  typedef enum int {
    MODE_STEADY,
    MODE_SENDER_IDLE,
    MODE_RECEIVER_STALL,
    MODE_BOTH_IDLE
  } idle_mode_e;

  // One character of the decimal text, as it leaves the block.
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } text_char_t;

  // --------------------------------------------------------------------------
  // Scoreboard: turns each accepted word into the characters it must produce
  // and compares the characters that come out, oldest first.
  // --------------------------------------------------------------------------
  class text_scoreboard;
    text_char_t  pending_text[$];
    int unsigned mismatches;

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Digits are collected least significant first, as repeated division
    // by ten yields them, then queued most significant first.
    function void note_word(logic [IN_VALUE_W-1:0] value, logic is_signed);
      logic [IN_VALUE_W-1:0] word;
      logic [IN_VALUE_W-1:0] mag;
      logic                  neg;
      digit_t                digits[$];
      text_char_t            tc;
      int                    k;

      word = value & WORD_MASK;
      neg  = is_signed && word[VW-1];
      // The magnitude is taken as an unsigned number, so the most negative
      // value keeps its full size.
      mag  = neg ? ((~word + 1'b1) & WORD_MASK) : word;
      do begin
        // Only the least significant digits fit when the slots run out.
        if (digits.size() < DS) begin
          digits.push_back(digit_t'(mag % 10));
        end
        mag = mag / 10;
      end while (mag != 0);

      if (neg) begin
        tc.character = CHAR_MINUS;
        tc.last      = 1'b0;
        pending_text.push_back(tc);
      end
      for (k = digits.size() - 1; k >= 0; k--) begin
        tc.character = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digits[k]};
        tc.last      = (k == 0);
        pending_text.push_back(tc);
      end
    endfunction

    task check_char(logic [CHAR_W-1:0] character, logic last);
      text_char_t want;
      if (pending_text.size() == 0) begin
        report($sformatf("character 0x%02h last %0b with no text pending", character, last));
      end else begin
        want = pending_text.pop_front();
        if (character !== want.character) begin
          report($sformatf("character 0x%02h, want 0x%02h", character, want.character));
        end
        if (last !== want.last) begin
          report($sformatf("last %0b on character 0x%02h, want %0b",
                           last, character, want.last));
        end
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  idta_in_if  in_ch ();
  idta_out_if out_ch ();

  integer_to_decimal_ascii #(
    .VALUE_WIDTH (VW),
    .DIGIT_SLOTS (DS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  text_scoreboard text_board = new;

  // Idling chances in percent, set by the stimulus per phase.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // Cycles left in a receiver hold-off; the stimulus loads it, the receiver
  // process counts it down.
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Receiver: ready is redrawn every cycle. A pending hold-off wins over the
  // random draw and keeps ready low for its whole length.
  // --------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and watchdog. Everything is sampled at the rising edge, before the
  // drivers' nonblocking updates land, so both channels are seen as the block
  // saw them. A word is noted before a character is checked in the same cycle,
  // although the block's latency keeps the two from belonging together.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        text_board.note_word(in_ch.value, in_ch.is_signed);
      end
      if (out_ch.valid && out_ch.ready) begin
        text_board.check_char(out_ch.character, out_ch.last);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles, %0d characters still pending",
                 quiet_cycles, text_board.pending_text.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Offers one word and returns on the edge at which it is taken. Valid is not
  // lowered on the way out: the next call either lowers it for a gap or keeps
  // it high with a new word, so valid gets one update per time step.
  task automatic send_word(input logic [IN_VALUE_W-1:0] v, input logic s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.value     <= v;
    in_ch.is_signed <= s;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic set_idle_mode(input idle_mode_e mode);
    case (mode)
      MODE_STEADY: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      MODE_SENDER_IDLE: begin
        send_idle_pct  = 83;
        recv_stall_pct = 0;
      end
      MODE_RECEIVER_STALL: begin
        send_idle_pct  = 0;
        recv_stall_pct = 83;
      end
      default: begin
        send_idle_pct  = 31;
        recv_stall_pct = 31;
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: a directed set of boundary words, then random phases.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [IN_VALUE_W-1:0] raw;
    logic [IN_VALUE_W-1:0] v;
    logic [IN_VALUE_W-1:0] pow;
    idle_mode_e            mode;
    int                    n;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.value     <= '0;
    in_ch.is_signed <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words run with both sides always ready.
    set_idle_mode(MODE_STEADY);
    // Zero gives a single character whichever way it is read.
    send_word(64'd0, 1'b0);
    send_word(64'd0, 1'b1);
    // Single digits and the first carries into a new digit.
    send_word(64'd1, 1'b0);
    send_word(64'd9, 1'b1);
    send_word(64'd10, 1'b0);
    send_word(64'd99, 1'b0);
    send_word(64'd100, 1'b1);
    // All ones: the largest unsigned value, and minus one when signed.
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    // The most negative signed value must print its full magnitude.
    send_word(64'h8000_0000_0000_0000, 1'b1);
    send_word(64'h8000_0000_0000_0000, 1'b0);
    // The largest positive signed value, read both ways.
    send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    // Ten to the nineteenth fills every digit slot; read signed it is negative.
    send_word(64'h8AC7_2304_89E8_0000, 1'b0);
    send_word(64'h8AC7_2304_89E8_0000, 1'b1);
    send_word(64'h8AC7_2304_89E7_FFFF, 1'b0);
    // Small negatives: minus ten and minus nine.
    send_word(64'hFFFF_FFFF_FFFF_FFF6, 1'b1);
    send_word(64'hFFFF_FFFF_FFFF_FFF7, 1'b1);
    // Alternating bit patterns.
    send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    send_word(64'h5555_5555_5555_5555, 1'b0);

    // Random phases. The steady phase opens with a long receiver hold-off
    // while words keep coming, so the block fills and stalls its input.
    for (int phase = 0; phase < 4; phase++) begin
      mode = idle_mode_e'(phase);
      set_idle_mode(mode);
      if (mode == MODE_STEADY) begin
        hold_left = HOLD_OFF_LEN;
      end
      for (n = 0; n < PHASE_WORDS; n++) begin
        raw = {$urandom, $urandom};
        case ($urandom_range(3))
          0: v = raw;
          // Right shifts spread the number of digits evenly.
          1: v = raw >> $urandom_range(IN_VALUE_W - 1);
          // Negated small values give short negative text when signed.
          2: v = ~(raw >> $urandom_range(IN_VALUE_W - 1)) + 1'b1;
          // Powers of ten and their neighbors, where digit counts change.
          default: begin
            pow = 64'd1;
            repeat ($urandom_range(19)) pow = pow * 64'd10;
            v = pow + 64'($urandom_range(2)) - 64'd1;
          end
        endcase
        send_word(v, 1'($urandom_range(1)));
      end
    end
    in_ch.valid <= 1'b0;

    // Let the last words drain, then watch a while longer for stray output.
    while (text_board.pending_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (text_board.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/idta_pkg.sv
hdl/idta_if.sv
hdl/idta_bin_shift.sv
hdl/idta_bcd_shift.sv
hdl/integer_to_decimal_ascii.sv
verif/tb_integer_to_decimal_ascii.sv
